// ===== rtl/etm_pkg.sv =====
package etm_pkg;

    localparam int ACC_W = 136;
    localparam int MPL_W = 66;
    localparam int DIV_W = ACC_W + 64;
    localparam int CNT_W = 7;

    typedef enum logic [3:0] {
        OP_P0  = 4'd0,
        OP_P1  = 4'd1,
        OP_Q0  = 4'd2,
        OP_Q1  = 4'd3,
        OP_R0  = 4'd4,
        OP_R1  = 4'd5,
        OP_X   = 4'd6,
        OP_D0  = 4'd7,
        OP_D1  = 4'd8,
        OP_NUM = 4'd9
    } mul_op_t;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_NEG  = 2'd2;

    typedef struct packed {
        logic    load_in;
        logic    mul_start;
        mul_op_t mul_op;
        logic    mul_step;
        logic    check;
        logic    div_load;
        logic    div_chk;
        logic    div_step;
        logic    sq_load;
        logic    sq_step;
        logic    out_load;
    } etm_cmd_t;

    typedef struct packed {
        logic last;
        logic d_zero;
        logic sign_bad;
        logic div_ge;
    } etm_stat_t;

endpackage

// ===== rtl/etm_ctrl.sv =====
module etm_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  etm_pkg::etm_stat_t stat,
    output etm_pkg::etm_cmd_t  cmd
);
    import etm_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_MSTART = 9'b000000010,
        S_MSTEP  = 9'b000000100,
        S_CHECK  = 9'b000001000,
        S_DLOAD  = 9'b000010000,
        S_DCHK   = 9'b000100000,
        S_DSTEP  = 9'b001000000,
        S_SQSTEP = 9'b010000000,
        S_RESULT = 9'b100000000
    } state_t;

    state_t  state_reg, state_next;
    mul_op_t op_reg, op_next;
    logic    out_valid_reg, out_valid_next;

    function automatic mul_op_t next_op(mul_op_t op);
        mul_op_t n;
        case (op)
            OP_P0:   n = OP_P1;
            OP_P1:   n = OP_Q0;
            OP_Q0:   n = OP_Q1;
            OP_Q1:   n = OP_R0;
            OP_R0:   n = OP_R1;
            OP_R1:   n = OP_X;
            OP_X:    n = OP_D0;
            OP_D0:   n = OP_D1;
            default: n = OP_NUM;
        endcase
        return n;
    endfunction

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.mul_op     = op_reg;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    op_next     = OP_P0;
                    state_next  = S_MSTART;
                end
            end
            S_MSTART: begin
                cmd.mul_start = 1'b1;
                state_next    = S_MSTEP;
            end
            S_MSTEP: begin
                cmd.mul_step = 1'b1;
                if (stat.last) begin
                    if (op_reg == OP_D1) begin
                        state_next = S_CHECK;
                    end else if (op_reg == OP_NUM) begin
                        state_next = S_DLOAD;
                    end else begin
                        op_next    = next_op(op_reg);
                        state_next = S_MSTART;
                    end
                end
            end
            S_CHECK: begin
                cmd.check = 1'b1;
                if (stat.d_zero || stat.sign_bad) begin
                    state_next = S_RESULT;
                end else begin
                    op_next    = OP_NUM;
                    state_next = S_MSTART;
                end
            end
            S_DLOAD: begin
                cmd.div_load = 1'b1;
                state_next   = S_DCHK;
            end
            S_DCHK: begin
                cmd.div_chk = 1'b1;
                state_next  = stat.div_ge ? S_RESULT : S_DSTEP;
            end
            S_DSTEP: begin
                cmd.div_step = 1'b1;
                if (stat.last) begin
                    cmd.sq_load = 1'b1;
                    state_next  = S_SQSTEP;
                end
            end
            S_SQSTEP: begin
                cmd.sq_step = 1'b1;
                if (stat.last) begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT: begin
                if (!out_valid_reg || m_ready) begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_P0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = out_valid_reg;

endmodule

// ===== rtl/etm_dpath.sv =====
module etm_dpath #(
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  etm_pkg::etm_cmd_t  cmd,
    output etm_pkg::etm_stat_t stat,
    input  logic [31:0]        scale_factor,
    input  logic signed [31:0] s_metric_11,
    input  logic signed [31:0] s_metric_12,
    input  logic signed [31:0] s_metric_13,
    input  logic signed [31:0] s_metric_22,
    input  logic signed [31:0] s_metric_23,
    input  logic signed [31:0] s_metric_33,
    input  logic               s_first_of_list,
    output logic [31:0]        m_time_error,
    output logic [31:0]        m_max_time_error,
    output logic [1:0]         m_status
);
    import etm_pkg::*;

    localparam int NUM_SHIFT = 2 * FRAC_BITS;

    logic [31:0]      g11_reg, g12_reg, g13_reg, g22_reg, g23_reg, g33_reg;
    logic [MPL_W-1:0] p_reg, q_reg, r_reg;
    logic [ACC_W-1:0] x_reg, d_reg;
    logic [ACC_W-1:0] acc_reg, mcand_reg;
    logic [MPL_W-1:0] mplier_reg;
    logic [CNT_W-1:0] cnt_reg;
    mul_op_t          op_reg;
    logic             neg_reg;
    logic [DIV_W-1:0] rem_reg, dsh_reg;
    logic [63:0]      quo_reg, v_reg, root_reg, bit_reg;
    logic [31:0]      t_reg, running_max_reg, max_next;
    logic [1:0]       st_reg;

    logic [ACC_W-1:0] sel_mcand, addend, acc_step, abs_x, den;
    logic [MPL_W-1:0] sel_mplier;
    logic [CNT_W-1:0] sel_cnt;
    logic             sel_clr, sel_neg, sub, ge;
    logic [63:0]      sq_sum;

    function automatic logic [ACC_W-1:0] ext_a(logic [31:0] v);
        return {{(ACC_W-32){v[31]}}, v};
    endfunction

    function automatic logic [MPL_W-1:0] ext_m(logic [31:0] v);
        return {{(MPL_W-32){v[31]}}, v};
    endfunction

    always_comb begin
        sel_mcand  = ext_a(g23_reg);
        sel_mplier = ext_m(g23_reg);
        sel_cnt    = CNT_W'(31);
        sel_clr    = 1'b1;
        sel_neg    = 1'b0;
        case (cmd.mul_op)
            OP_P0: begin
                sel_mcand  = ext_a(g23_reg);
                sel_mplier = ext_m(g23_reg);
            end
            OP_P1: begin
                sel_mcand  = ext_a(g22_reg);
                sel_mplier = ext_m(g33_reg);
                sel_clr    = 1'b0;
                sel_neg    = 1'b1;
            end
            OP_Q0: begin
                sel_mcand  = ext_a(g12_reg);
                sel_mplier = ext_m(g23_reg);
            end
            OP_Q1: begin
                sel_mcand  = ext_a(g22_reg);
                sel_mplier = ext_m(g13_reg);
                sel_clr    = 1'b0;
                sel_neg    = 1'b1;
            end
            OP_R0: begin
                sel_mcand  = ext_a(g12_reg);
                sel_mplier = ext_m(g12_reg);
            end
            OP_R1: begin
                sel_mcand  = ext_a(g22_reg);
                sel_mplier = ext_m(g11_reg);
                sel_clr    = 1'b0;
                sel_neg    = 1'b1;
            end
            OP_X: begin
                sel_mcand  = {{(ACC_W-MPL_W){p_reg[MPL_W-1]}}, p_reg};
                sel_mplier = ext_m(g22_reg);
            end
            OP_D0: begin
                sel_mcand  = {{(ACC_W-MPL_W){q_reg[MPL_W-1]}}, q_reg};
                sel_mplier = q_reg;
                sel_cnt    = CNT_W'(MPL_W - 1);
            end
            OP_D1: begin
                sel_mcand  = {{(ACC_W-MPL_W){p_reg[MPL_W-1]}}, p_reg};
                sel_mplier = r_reg;
                sel_cnt    = CNT_W'(MPL_W - 1);
                sel_clr    = 1'b0;
                sel_neg    = 1'b1;
            end
            OP_NUM: begin
                sel_mcand  = abs_x;
                sel_mplier = {{(MPL_W-32){1'b0}}, scale_factor};
                sel_cnt    = CNT_W'(32);
            end
            default: begin
                sel_clr = 1'b1;
            end
        endcase
    end

    assign abs_x    = x_reg[ACC_W-1] ? (~x_reg + 1'b1) : x_reg;
    assign den      = d_reg[ACC_W-1] ? (~d_reg + 1'b1) : d_reg;
    assign addend   = mplier_reg[0] ? mcand_reg : '0;
    assign sub      = neg_reg ^ ((cnt_reg == '0) && mplier_reg[0]);
    assign acc_step = sub ? (acc_reg - addend) : (acc_reg + addend);
    assign ge       = (rem_reg >= dsh_reg);
    assign sq_sum   = root_reg + bit_reg;

    assign stat.last     = (cnt_reg == '0);
    assign stat.d_zero   = (d_reg == '0);
    assign stat.sign_bad = (x_reg[ACC_W-1] != d_reg[ACC_W-1]);
    assign stat.div_ge   = ge;

    always_comb begin
        max_next = running_max_reg;
        if ((st_reg == ST_OK) && (t_reg > running_max_reg)) begin
            max_next = t_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            g11_reg <= s_metric_11;
            g12_reg <= s_metric_12;
            g13_reg <= s_metric_13;
            g22_reg <= s_metric_22;
            g23_reg <= s_metric_23;
            g33_reg <= s_metric_33;
            t_reg   <= '0;
            st_reg  <= ST_OK;
        end
        if (cmd.mul_start) begin
            mcand_reg  <= sel_mcand;
            mplier_reg <= sel_mplier;
            cnt_reg    <= sel_cnt;
            op_reg     <= cmd.mul_op;
            neg_reg    <= sel_neg;
            if (sel_clr) begin
                acc_reg <= '0;
            end
        end
        if (cmd.mul_step) begin
            acc_reg    <= acc_step;
            mcand_reg  <= mcand_reg << 1;
            mplier_reg <= mplier_reg >> 1;
            cnt_reg    <= cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                case (op_reg)
                    OP_P1:   p_reg <= acc_step[MPL_W-1:0];
                    OP_Q1:   q_reg <= acc_step[MPL_W-1:0];
                    OP_R1:   r_reg <= acc_step[MPL_W-1:0];
                    OP_X:    x_reg <= acc_step;
                    OP_D1:   d_reg <= acc_step;
                    default: ;
                endcase
            end
        end
        if (cmd.check) begin
            if (d_reg == '0) begin
                st_reg <= ST_ZERO;
            end else if (x_reg[ACC_W-1] != d_reg[ACC_W-1]) begin
                st_reg <= ST_NEG;
            end
        end
        if (cmd.div_load) begin
            rem_reg <= {{(DIV_W-ACC_W){1'b0}}, acc_reg} << NUM_SHIFT;
            dsh_reg <= {den, 64'd0};
            quo_reg <= '0;
        end
        if (cmd.div_chk) begin
            if (ge) begin
                t_reg <= 32'hFFFF_FFFF;
            end
            dsh_reg <= dsh_reg >> 1;
            cnt_reg <= CNT_W'(63);
        end
        if (cmd.div_step) begin
            if (ge) begin
                rem_reg <= rem_reg - dsh_reg;
            end
            quo_reg <= {quo_reg[62:0], ge};
            dsh_reg <= dsh_reg >> 1;
            cnt_reg <= (cnt_reg == '0) ? CNT_W'(31) : (cnt_reg - 1'b1);
        end
        if (cmd.sq_load) begin
            v_reg    <= {quo_reg[62:0], ge};
            root_reg <= '0;
            bit_reg  <= 64'h4000_0000_0000_0000;
        end
        if (cmd.sq_step) begin
            if (v_reg >= sq_sum) begin
                v_reg    <= v_reg - sq_sum;
                root_reg <= (root_reg >> 1) + bit_reg;
                if (cnt_reg == '0) begin
                    t_reg <= 32'((root_reg >> 1) + bit_reg);
                end
            end else begin
                root_reg <= root_reg >> 1;
                if (cnt_reg == '0) begin
                    t_reg <= 32'(root_reg >> 1);
                end
            end
            bit_reg <= bit_reg >> 2;
            cnt_reg <= cnt_reg - 1'b1;
        end
        if (cmd.out_load) begin
            m_time_error     <= t_reg;
            m_max_time_error <= max_next;
            m_status         <= st_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_max_reg <= '0;
        end else if (cmd.load_in && s_first_of_list) begin
            running_max_reg <= '0;
        end else if (cmd.out_load) begin
            running_max_reg <= max_next;
        end
    end

endmodule

// ===== rtl/ellipsoid_time_error_max_core.sv =====
// Computes the ellipsoid time error sqrt(scale * x / d) of each set of six metric
// components, as unsigned fixed point saturated at all ones, together with the
// running maximum since the last first-of-list request and a status code. One
// request is processed at a time: a shared bit-serial multiplier forms the nine
// signed products and the scaled numerator, each after a start step, then a
// restoring divider, with its load and first compare, and a bit-wise square root
// finish the result. A request that ends with a zero denominator or a negative
// ratio returns after the nine products, without the numerator, and a saturated
// request returns after the divider's first compare.
// The next request is taken while the previous request's result waits in the
// output register.
module ellipsoid_time_error_max_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_metric_11,
    input  logic signed [31:0] s_metric_12,
    input  logic signed [31:0] s_metric_13,
    input  logic signed [31:0] s_metric_22,
    input  logic signed [31:0] s_metric_23,
    input  logic signed [31:0] s_metric_33,
    input  logic               s_first_of_list,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [31:0]        m_time_error,
    output logic [31:0]        m_max_time_error,
    output logic [1:0]         m_status
);
    import etm_pkg::*;

    localparam logic [2:0] ADDR_SCALE = 3'd0;

    logic [31:0] scale_reg;
    etm_cmd_t    cmd;
    etm_stat_t   stat;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_SCALE) ? scale_reg : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= 32'd65536;
        end else if (psel && penable && pwrite && (paddr == ADDR_SCALE)) begin
            scale_reg <= pwdata;
        end
    end

    etm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    etm_dpath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .stat             (stat),
        .scale_factor     (scale_reg),
        .s_metric_11      (s_metric_11),
        .s_metric_12      (s_metric_12),
        .s_metric_13      (s_metric_13),
        .s_metric_22      (s_metric_22),
        .s_metric_23      (s_metric_23),
        .s_metric_33      (s_metric_33),
        .s_first_of_list  (s_first_of_list),
        .m_time_error     (m_time_error),
        .m_max_time_error (m_max_time_error),
        .m_status         (m_status)
    );

endmodule

// ===== tb/sv/etm_checker.sv =====
`timescale 1ns / 100ps

module etm_checker
    import etm_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic signed [31:0] s_metric_11,
    input  logic signed [31:0] s_metric_12,
    input  logic signed [31:0] s_metric_13,
    input  logic signed [31:0] s_metric_22,
    input  logic signed [31:0] s_metric_23,
    input  logic signed [31:0] s_metric_33,
    input  logic               s_first_of_list,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [31:0]        m_time_error,
    input  logic [31:0]        m_max_time_error,
    input  logic [1:0]         m_status,
    output int                 fail_count,
    output int                 pending_count,
    output int                 status_seen [3]
);

    localparam logic [2:0] ADDR_SCALE = 3'd0;

    typedef struct {
        logic [31:0] time_error;
        logic [31:0] max_time_error;
        logic [1:0]  status;
    } timing_result_t;

    timing_result_t expected_results[$];
    logic [31:0]    scale_reg;
    logic [31:0]    running_peak;

    function automatic logic [31:0] root_floor(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = '0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r[31:0];
    endfunction

    function automatic timing_result_t time_error_of(
        input logic signed [31:0] m11, m12, m13, m22, m23, m33,
        input logic first);
        logic signed [255:0] g11, g12, g13, g22, g23, g33, p, q, r, x, d;
        logic [255:0]        ax, ad, num;
        logic [63:0]         quo;
        timing_result_t      res;
        g11 = m11; g12 = m12; g13 = m13; g22 = m22; g23 = m23; g33 = m33;
        if (first) running_peak = '0;
        p = g23 * g23 - g22 * g33;
        q = g12 * g23 - g22 * g13;
        r = g12 * g12 - g22 * g11;
        x = p * g22;
        d = q * q - p * r;
        res.time_error = '0;
        if (d == 0) begin
            res.status = ST_ZERO;
        end else if (x[255] != d[255]) begin
            res.status = ST_NEG;
        end else begin
            res.status = ST_OK;
            ax = x[255] ? -x : x;
            ad = d[255] ? -d : d;
            num = ({224'd0, scale_reg} * ax) << (2 * FRAC_BITS);
            if (num >= (ad << 64)) begin
                res.time_error = 32'hFFFF_FFFF;
            end else begin
                quo = 64'(num / ad);
                res.time_error = root_floor(quo);
            end
            if (res.time_error > running_peak) running_peak = res.time_error;
        end
        res.max_time_error = running_peak;
        return res;
    endfunction

    assign pending_count = expected_results.size();

    always @(posedge aclk) begin
        timing_result_t want;
        if (!aresetn) begin
            scale_reg    <= 32'd65536;
            running_peak = '0;
            expected_results.delete();
            fail_count   <= 0;
            for (int i = 0; i < 3; i++) status_seen[i] <= 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == ADDR_SCALE)
                scale_reg <= pwdata;
            if (s_valid && s_ready)
                expected_results.push_back(time_error_of(s_metric_11, s_metric_12,
                    s_metric_13, s_metric_22, s_metric_23, s_metric_33,
                    s_first_of_list));
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, got te %h max %h status %0d",
                             $time, m_time_error, m_max_time_error, m_status);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (m_status <= ST_NEG) status_seen[m_status] <= status_seen[m_status] + 1;
                    if (want.time_error !== m_time_error ||
                        want.max_time_error !== m_max_time_error ||
                        want.status !== m_status) begin
                        $display("%0t: mismatch, expected te %h max %h status %0d, got te %h max %h status %0d",
                                 $time, want.time_error, want.max_time_error, want.status,
                                 m_time_error, m_max_time_error, m_status);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import etm_pkg::*;

    localparam int      CYCLE_LIMIT = 4_000_000;
    localparam logic [2:0] ADDR_SCALE = 3'd0;
    localparam logic signed [31:0] ONE = 32'sh0001_0000;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [31:0] s_metric_11 = '0, s_metric_12 = '0, s_metric_13 = '0;
    logic signed [31:0] s_metric_22 = '0, s_metric_23 = '0, s_metric_33 = '0;
    logic               s_first_of_list = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [31:0]        m_time_error, m_max_time_error;
    logic [1:0]         m_status;

    int fail_count, pending_count;
    int status_seen [3];
    int send_idle_pct = 0, recv_idle_pct = 0;
    int requests_sent = 0;
    int cycle_count = 0;

    always #4 aclk = ~aclk;

    ellipsoid_time_error_max_core u_dut (.*);

    etm_checker u_chk (.*);

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("ellipsoid_time_error_max_core regression: fail");
            $finish;
        end
    end

    always @(negedge aclk) m_ready <= ($urandom_range(99) >= recv_idle_pct);

    task automatic write_scale(input logic [31:0] value);
        @(negedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_SCALE; pwdata <= value; penable <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic send_request(input logic signed [31:0] g11, g12, g13, g22, g23, g33,
                                input logic first);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_metric_11 <= g11; s_metric_12 <= g12; s_metric_13 <= g13;
        s_metric_22 <= g22; s_metric_23 <= g23; s_metric_33 <= g33;
        s_first_of_list <= first;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        s_valid <= 1'b0;
        requests_sent++;
    endtask

    function automatic logic signed [31:0] rand_metric(input int kind);
        logic signed [31:0] v;
        case (kind)
            0: begin
                v = $signed(16'($urandom)) <<< $urandom_range(0, 8);
            end
            1: begin
                v = $signed(24'($urandom));
            end
            default: begin
                v = $urandom;
            end
        endcase
        return v;
    endfunction

    task automatic send_random;
        int kind, shape;
        logic signed [31:0] g [6];
        kind  = $urandom_range(0, 2);
        shape = $urandom_range(99);
        for (int i = 0; i < 6; i++) g[i] = rand_metric($urandom_range(0, 2) == 0 ? 2 : kind);
        if (shape < 10) begin
            g[3] = '0;
            g[1] = '0;
        end else if (shape < 13) begin
            foreach (g[i]) g[i] = '0;
        end else if (shape < 25) begin
            g[0] = ONE; g[3] = ONE; g[5] = ONE;
            g[1] = $signed(12'($urandom)); g[2] = $signed(12'($urandom));
            g[4] = $signed(12'($urandom));
        end
        send_request(g[0], g[1], g[2], g[3], g[4], g[5], $urandom_range(7) == 0);
    endtask

    task automatic drain;
        while (pending_count != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic run_phase(input logic [31:0] scale, input int count,
                             input int send_pct, input int recv_pct);
        drain();
        write_scale(scale);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (count) send_random();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_request('0, '0, '0, '0, '0, '0, 1'b1);
        send_request(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                     32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
        send_request(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                     32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0);
        send_request(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                     32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
        send_request(ONE, '0, '0, ONE, '0, ONE, 1'b0);
        send_request(ONE, 32'sh0000_4000, 32'sh0000_2000, ONE, 32'sh0000_1000, ONE, 1'b0);
        send_request(ONE, 32'sh0000_8000, 32'sh0000_1000, -ONE, 32'sh0000_3000, ONE, 1'b0);
        send_request(-ONE, 32'sh0000_0100, 32'sh0000_0200, ONE, 32'sh0000_0300, -ONE, 1'b0);
        send_request(32'sh0000_0001, 32'sh0000_0001, '0, 32'sh0000_0002, 32'sh0000_0001,
                     32'sh7FFF_FFFF, 1'b0);
        send_request('0, '0, ONE, '0, ONE, ONE, 1'b1);
        send_request(ONE, '0, '0, ONE, '0, ONE, 1'b0);
        send_request(32'sh0000_0003, 32'sh0000_0001, 32'sh0000_0001, 32'sh0000_0002,
                     32'sh0000_0001, 32'sh0000_0002, 1'b1);

        run_phase(32'hFFFF_FFFF, 12, 17, 57);
        send_request(32'sh0000_0003, 32'sh0000_0001, 32'sh0000_0001, 32'sh0000_0002,
                     32'sh0000_0001, 32'sh0000_0002, 1'b0);
        run_phase(32'd1, 330, 17, 57);
        run_phase($urandom, 330, 17, 57);
        run_phase(32'd0, 30, 57, 17);
        run_phase(32'hFFFF_FFFF, 300, 57, 17);
        run_phase(32'd65536, 330, 0, 0);

        drain();
        repeat (600) @(posedge aclk);
        $display("Sent %0d requests over six scale settings including zero and both extremes.",
                 requests_sent);
        $display("Results by status: %0d ok, %0d zero denominator, %0d negative ratio.",
                 status_seen[0], status_seen[1], status_seen[2]);
        if (fail_count == 0) begin
            $display("ellipsoid_time_error_max_core regression: pass");
        end else begin
            $display("ellipsoid_time_error_max_core regression: fail");
        end
        $finish;
    end

endmodule
